/* hdl/srfo_pkg.sv */
package srfo_pkg;

  // Default table depth
  localparam int MAX_SECTIONS_DEF = 16;

  // Field widths
  localparam int ADDR_W  = 32;
  localparam int SLOT_W  = 4;
  localparam int COUNT_W = 5;

  // Config port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_FILE_ALIGN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECTION_ALIGN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECTION_COUNT = 2'd2;

  localparam logic [ADDR_W-1:0]  FILE_ALIGN_RST    = 32'h0000_0200;
  localparam logic [ADDR_W-1:0]  SECTION_ALIGN_RST = 32'h0000_1000;
  localparam logic [COUNT_W-1:0] SECTION_COUNT_RST = 5'd0;

  // Alignment constants
  localparam logic [ADDR_W-1:0] RAW_GRAIN        = 32'h0000_0200;
  localparam logic [ADDR_W-1:0] BIG_SECT_ALIGN   = 32'h0000_1000;

  // Remainder unit: one quotient bit per step
  localparam int DIV_STEPS = ADDR_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Item actions
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_XLATE = 1'b1;

  typedef struct packed {
    logic              action;
    logic [SLOT_W-1:0] entry_index;
    logic [ADDR_W-1:0] region_start;
    logic [ADDR_W-1:0] region_length;
    logic [ADDR_W-1:0] raw_pointer;
    logic [ADDR_W-1:0] rva;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] file_offset;
    logic              not_found;
  } out_item_t;

  // One section table row
  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] length;
    logic [ADDR_W-1:0] raw;
  } sect_t;

endpackage

/* hdl/section_rva_to_file_offset_top.sv */
// Section table RVA-to-file-offset translator. A load item (action 0) writes one
// section row (start, length, raw pointer) into a synchronous table RAM on transfer
// and returns nothing; slots at or beyond MAX_SECTIONS are dropped. A translate item
// (action 1) scans rows 0..min(section_count, MAX_SECTIONS)-1 in order, one row per
// cycle through the RAM read port, and takes the first with start <= rva <
// start+length (32-bit wrapping end). The hit's start is floored to the effective
// alignment by a bit-serial remainder unit (skipped when that alignment is zero).
// One item is in flight at a time. The result sits in an output register, so the
// next item may be accepted while it waits for out_ready.
// Configuration must only be written while no item is in progress.
module section_rva_to_file_offset_top #(
  parameter int MAX_SECTIONS = srfo_pkg::MAX_SECTIONS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  srfo_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output srfo_pkg::out_item_t                  out_data,
  input  logic                                 cfg_we,
  input  logic [srfo_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [srfo_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  import srfo_pkg::*;

  // Table address and search counter widths
  localparam int AW    = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int IDX_W = $clog2(MAX_SECTIONS + 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,  // waiting for an item
    ST_LOOK = 5'b00010,  // compare one table row per cycle
    ST_ADJ  = 5'b00100,  // add floored raw pointer
    ST_DIV  = 5'b01000,  // start % alignment, one bit per cycle
    ST_DONE = 5'b10000   // hand result to output register
  } state_t;

  state_t               state_r, state_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [IDX_W-1:0]     limit_r, limit_nxt;
  logic [ADDR_W-1:0]    rva_r, rva_nxt;
  logic [ADDR_W-1:0]    acc_r, acc_nxt;      // rva - start, then + raw
  logic [ADDR_W-1:0]    raw_r, raw_nxt;
  logic [ADDR_W-1:0]    dvd_r, dvd_nxt;      // dividend shifter
  logic [ADDR_W-1:0]    rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 nf_r, nf_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;

  logic [ADDR_W-1:0]    file_align_r;
  logic [ADDR_W-1:0]    section_align_r;
  logic [COUNT_W-1:0]   section_count_r;

  // Table RAM
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  sect_t                ram_wdata;
  logic [AW-1:0]        ram_raddr;
  sect_t                ram_rdata;

  logic                 in_xfer;
  logic [ADDR_W-1:0]    eff_align;
  logic [ADDR_W-1:0]    raw_floor;
  logic [ADDR_W-1:0]    sect_end;
  logic                 hit;
  logic [IDX_W-1:0]     idx_inc;
  logic [ADDR_W-1:0]    count_ext;
  logic [IDX_W-1:0]     limit_cur;
  logic [ADDR_W:0]      trial;
  logic [ADDR_W:0]      shifted;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_align_r    <= FILE_ALIGN_RST;
      section_align_r <= SECTION_ALIGN_RST;
      section_count_r <= SECTION_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FILE_ALIGN:    file_align_r    <= cfg_wdata;
        CFG_SECTION_ALIGN: section_align_r <= cfg_wdata;
        CFG_SECTION_COUNT: section_count_r <= cfg_wdata[COUNT_W-1:0];
        default: ;  // unknown index ignored
      endcase
    end
  end

  // Loads go straight into the table on transfer
  assign ram_we    = in_xfer && (in_data.action == ACT_LOAD) &&
                     (ADDR_W'(in_data.entry_index) < ADDR_W'(MAX_SECTIONS));
  assign ram_waddr = AW'(in_data.entry_index);
  assign ram_wdata = '{start:  in_data.region_start,
                       length: in_data.region_length,
                       raw:    in_data.raw_pointer};
  assign ram_raddr = idx_nxt[AW-1:0];

  srfo_ram #(
    .WIDTH  ($bits(sect_t)),
    .DEPTH  (MAX_SECTIONS),
    .ADDR_W (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Alignment selection
  assign eff_align = (section_align_r < BIG_SECT_ALIGN) ? file_align_r : section_align_r;
  assign raw_floor = (file_align_r < RAW_GRAIN) ? ram_rdata.raw
                                                : (ram_rdata.raw & ~(RAW_GRAIN - 1'b1));

  // Row match, end wraps mod 2^32
  assign sect_end = ram_rdata.start + ram_rdata.length;
  assign hit      = (rva_r >= ram_rdata.start) && (rva_r < sect_end);
  assign idx_inc  = idx_r + 1'b1;

  // Search limit, clipped to the table depth
  assign count_ext = ADDR_W'(section_count_r);
  assign limit_cur = (count_ext > ADDR_W'(MAX_SECTIONS)) ? IDX_W'(MAX_SECTIONS)
                                                         : IDX_W'(section_count_r);

  // Restoring remainder step
  assign shifted = {rem_r, dvd_r[ADDR_W-1]};
  assign trial   = shifted - {1'b0, eff_align};

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    limit_nxt     = limit_r;
    rva_nxt       = rva_r;
    acc_nxt       = acc_r;
    raw_nxt       = raw_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    nf_nxt        = nf_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      ST_IDLE: begin
        idx_nxt = '0;
        if (in_xfer && (in_data.action == ACT_XLATE)) begin
          rva_nxt   = in_data.rva;
          limit_nxt = limit_cur;
          if (limit_cur == '0) begin
            acc_nxt   = '0;
            rem_nxt   = '0;
            nf_nxt    = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_LOOK;
          end
        end
      end

      ST_LOOK: begin
        if (hit) begin
          acc_nxt   = rva_r - ram_rdata.start;
          raw_nxt   = raw_floor;
          dvd_nxt   = ram_rdata.start;
          rem_nxt   = '0;
          nf_nxt    = 1'b0;
          state_nxt = ST_ADJ;
        end else if (idx_inc == limit_r) begin
          acc_nxt   = '0;
          rem_nxt   = '0;
          nf_nxt    = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          idx_nxt = idx_inc;
        end
      end

      ST_ADJ: begin
        acc_nxt = acc_r + raw_r;
        cnt_nxt = '0;
        // zero alignment: start is used unfloored, remainder stays 0
        state_nxt = (eff_align == '0) ? ST_DONE : ST_DIV;
      end

      ST_DIV: begin
        rem_nxt = trial[ADDR_W] ? shifted[ADDR_W-1:0] : trial[ADDR_W-1:0];
        dvd_nxt = {dvd_r[ADDR_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        // offset = rva + raw - (start - start % align)
        if (!out_valid_r || out_ready) begin
          out_data_nxt.file_offset = acc_r + rem_r;
          out_data_nxt.not_found   = nf_r;
          out_valid_nxt            = 1'b1;
          state_nxt                = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers, no reset
  always_ff @(posedge clk) begin
    limit_r    <= limit_nxt;
    rva_r      <= rva_nxt;
    acc_r      <= acc_nxt;
    raw_r      <= raw_nxt;
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    nf_r       <= nf_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

/* hdl/srfo_ram.sv */
module srfo_ram #(
  parameter int WIDTH  = 96,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* sim/testbench.sv */
module testbench;
  import srfo_pkg::*;

  localparam int SLOTS           = MAX_SECTIONS_DEF;
  localparam int CYCLE_LIMIT     = 500000;
  localparam int SETTLE_CYCLES   = 64;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 166;
  localparam int MAX_PRINTS      = 40;
  // index 3 has no register behind it; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // Section table shadow, register shadow and the queue of offsets owed by the block.
  class offset_ledger;
    logic [ADDR_W-1:0]  file_align;
    logic [ADDR_W-1:0]  section_align;
    logic [COUNT_W-1:0] count;
    logic [ADDR_W-1:0]  tbl_start [SLOTS];
    logic [ADDR_W-1:0]  tbl_len   [SLOTS];
    logic [ADDR_W-1:0]  tbl_raw   [SLOTS];
    out_item_t          pending_offsets [$];
    int                 mismatches, loads, hits, misses, printed;

    function new();
      file_align    = FILE_ALIGN_RST;
      section_align = SECTION_ALIGN_RST;
      count         = SECTION_COUNT_RST;
      foreach (tbl_start[i]) begin
        tbl_start[i] = '0;
        tbl_len[i]   = '0;
        tbl_raw[i]   = '0;
      end
      mismatches = 0;
      loads      = 0;
      hits       = 0;
      misses     = 0;
      printed    = 0;
    endfunction

    function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_FILE_ALIGN:    file_align    = data;
        CFG_SECTION_ALIGN: section_align = data;
        CFG_SECTION_COUNT: count         = data[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    function out_item_t predict_offset(input logic [ADDR_W-1:0] rva);
      out_item_t         r;
      int unsigned       rows;
      logic [ADDR_W-1:0] row_end, raw_f, start_f, grain;
      r.file_offset = '0;
      r.not_found   = 1'b1;
      rows = (count > SLOTS) ? SLOTS : count;
      for (int i = 0; i < rows; i++) begin
        row_end = tbl_start[i] + tbl_len[i];  // wraps mod 2^32
        if (rva >= tbl_start[i] && rva < row_end) begin
          raw_f = (file_align < RAW_GRAIN) ? tbl_raw[i] : (tbl_raw[i] & ~(RAW_GRAIN - 1));
          grain = (section_align < BIG_SECT_ALIGN) ? file_align : section_align;
          start_f = (grain == '0) ? tbl_start[i] : tbl_start[i] - (tbl_start[i] % grain);
          r.file_offset = rva + raw_f - start_f;
          r.not_found   = 1'b0;
          return r;
        end
      end
      return r;
    endfunction

    function void note_transfer(input in_item_t it);
      if (it.action == ACT_LOAD) begin
        loads++;
        if (it.entry_index < SLOTS) begin
          tbl_start[it.entry_index] = it.region_start;
          tbl_len[it.entry_index]   = it.region_length;
          tbl_raw[it.entry_index]   = it.raw_pointer;
        end
      end else begin
        pending_offsets.insert(pending_offsets.size(), predict_offset(it.rva));
      end
    endfunction

    task report_mismatch(input string what);
      mismatches++;
      if (printed < MAX_PRINTS) begin
        printed++;
        $display("[%0t] MISMATCH: %s", $time, what);
      end
    endtask

    task check_transfer(input out_item_t got);
      out_item_t want;
      if (pending_offsets.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: offset=%h not_found=%b",
                                  got.file_offset, got.not_found));
        return;
      end
      want = pending_offsets.pop_front();
      if (want.not_found) misses++;
      else hits++;
      if (got.not_found !== want.not_found)
        report_mismatch($sformatf("not_found got %b want %b", got.not_found, want.not_found));
      if (got.file_offset !== want.file_offset)
        report_mismatch($sformatf("file_offset got %h want %h", got.file_offset,
                                  want.file_offset));
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  in_item_t              in_data   = '0;
  logic                  out_ready = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_FILE_ALIGN;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_ready;
  logic                  out_valid;
  out_item_t             out_data;

  logic                  calm = 1'b0;  // no idling on either side while set
  int                    cycle_count = 0;
  offset_ledger          ledger;

  section_rva_to_file_offset_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a lost result ends up here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still owed", cycle_count,
               ledger.pending_offsets.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Monitors sample pre-edge values; all TB drives are nonblocking, so no race.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) ledger.note_transfer(in_data);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) ledger.check_transfer(out_data);
  end

  // Receiver backpressure: ~7% stall cycles, none in the calm stretch.
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 7);
  end

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    if (calm) return 0;
    if ($urandom_range(99) < 7) return $urandom_range(1, 5);
    return 0;
  endfunction

  // Returns in the time step of the edge where the transfer happened; valid stays
  // high so a back-to-back item needs no second assignment in that step.
  task automatic drive_item(input in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid, wait for every owed result, then let a trailing load or
  // translate finish inside the block.
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (ledger.pending_offsets.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // All registers in one burst, plus a write to the unused index.
  task automatic write_config(input logic [CFG_DATA_W-1:0] fa, input logic [CFG_DATA_W-1:0] sa,
                              input logic [CFG_DATA_W-1:0] cnt_word);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FILE_ALIGN;
    cfg_wdata <= fa;
    @(posedge clk);
    ledger.set_reg(CFG_FILE_ALIGN, fa);
    cfg_index <= CFG_SECTION_ALIGN;
    cfg_wdata <= sa;
    @(posedge clk);
    ledger.set_reg(CFG_SECTION_ALIGN, sa);
    cfg_index <= CFG_UNUSED;
    cfg_wdata <= $urandom;
    @(posedge clk);
    cfg_index <= CFG_SECTION_COUNT;
    cfg_wdata <= cnt_word;
    @(posedge clk);
    ledger.set_reg(CFG_SECTION_COUNT, cnt_word);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Loads: mostly compact sections, plus empty, wrapping and fully random ones.
  function automatic in_item_t make_load(input logic [SLOT_W-1:0] slot);
    in_item_t    it;
    int unsigned mode;
    it.action        = ACT_LOAD;
    it.entry_index   = slot;
    it.region_start  = $urandom;
    it.region_length = $urandom;
    it.raw_pointer   = $urandom;
    it.rva           = $urandom;
    mode = $urandom_range(99);
    if (mode < 60) begin
      it.region_length = $urandom_range(1, 32'h0002_0000);
    end else if (mode < 70) begin
      it.region_length = '0;
    end else if (mode < 85) begin
      // start near the top so start+length usually wraps past zero
      it.region_start  = 32'hFFFF_FFFF - $urandom_range(0, 32'h0000_FFFF);
      it.region_length = $urandom_range(1, 32'h0002_0000);
    end
    return it;
  endfunction

  // Translates: mostly aimed at a searched row (edges and interior), rest random.
  function automatic in_item_t make_xlate();
    in_item_t          it;
    int unsigned       rows, row;
    logic [ADDR_W-1:0] s, n;
    it.action        = ACT_XLATE;
    it.entry_index   = SLOT_W'($urandom);
    it.region_start  = $urandom;
    it.region_length = $urandom;
    it.raw_pointer   = $urandom;
    it.rva           = $urandom;
    rows = (ledger.count > SLOTS) ? SLOTS : ledger.count;
    if (rows != 0 && $urandom_range(99) < 65) begin
      row = $urandom_range(0, rows - 1);
      s   = ledger.tbl_start[row];
      n   = ledger.tbl_len[row];
      case ($urandom_range(3))
        0:       it.rva = s;
        1:       it.rva = s + n - 1;
        2:       it.rva = s + n;  // first address past the row
        default: it.rva = (n == '0) ? s : s + ($urandom % n);
      endcase
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    in_item_t          it;
    logic [ADDR_W-1:0] fa, sa, cnt;
    logic [ADDR_W-1:0] probes [7];

    ledger = new();
    probes = '{32'h0000_1000, 32'h0000_2FFF, 32'h0000_3000, 32'h0001_0FFF,
               32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h0017_7FFF};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings, nothing searched yet -> both ends of rva miss.
    it = make_xlate();
    it.rva = '0;
    drive_item(it);
    it = make_xlate();
    it.rva = 32'hFFFF_FFFF;
    drive_item(it);

    // Fill every slot before any search reaches it.
    for (int i = 0; i < SLOTS; i++) begin
      it = make_load(SLOT_W'(i));
      case (i)
        0: begin  // base row
          it.region_start = 32'h0000_1000; it.region_length = 32'h0000_2000;
          it.raw_pointer  = 32'h0000_0400;
        end
        1: begin  // overlaps row 0, must lose to it
          it.region_start = 32'h0000_1000; it.region_length = 32'h0000_0100;
          it.raw_pointer  = 32'h0000_9999;
        end
        2: begin  // empty section
          it.region_start = '0; it.region_length = '0; it.raw_pointer = 32'hFFFF_FFFF;
        end
        3: begin  // end wraps below start
          it.region_start = 32'hFFFF_F000; it.region_length = 32'h0000_2000;
          it.raw_pointer  = '0;
        end
        4: begin  // unaligned start and raw pointer
          it.region_start = 32'h0001_0234; it.region_length = 32'h0000_1000;
          it.raw_pointer  = 32'h0000_03FF;
        end
        5: begin  // reaches the top, end exclusive at all-ones
          it.region_start = 32'h8000_0000; it.region_length = 32'h7FFF_FFFF;
          it.raw_pointer  = 32'hFFFF_FE01;
        end
        6: begin  // single byte at the top, end wraps to zero
          it.region_start = 32'hFFFF_FFFF; it.region_length = 32'h0000_0001;
          it.raw_pointer  = 32'h1234_5678;
        end
        15: begin  // catch-all below all-ones
          it.region_start = '0; it.region_length = 32'hFFFF_FFFF; it.raw_pointer = '0;
        end
        default: begin
          it.region_start  = 32'h0010_0000 + i * 32'h0001_0000;
          it.region_length = 32'h0000_8000;
          it.raw_pointer   = i * 32'h0000_1000 + 32'h123;
        end
      endcase
      drive_item(it);
    end

    settle_idle();
    write_config(FILE_ALIGN_RST, SECTION_ALIGN_RST, 32'd16);
    foreach (probes[i]) begin
      it = make_xlate();
      it.rva = probes[i];
      drive_item(it);
    end

    // Random phases, each under its own register setting.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin fa = '0;           sa = '0;           cnt = 32'd31; end  // no flooring
        1: begin fa = 32'h0000_01FF; sa = 32'h0000_0FFF; cnt = 32'd17; end
        2: begin fa = 32'hFFFF_FFFF; sa = 32'hFFFF_FFFF; cnt = 32'd1;  end
        3: begin fa = $urandom;      sa = $urandom;      cnt = $urandom_range(2, 15); end
        4: begin fa = $urandom_range(1, 32'h1FF); sa = '0; cnt = '0; end  // nothing searched
        5: begin fa = FILE_ALIGN_RST; sa = SECTION_ALIGN_RST; cnt = 32'd8; end
        6: begin fa = 32'd3;         sa = 32'h0000_0800; cnt = 32'd16; end  // odd divisor
        default: begin
          fa  = $urandom_range(0, 32'h3FF);
          sa  = BIG_SECT_ALIGN << $urandom_range(0, 8);
          cnt = 32'd16;
        end
      endcase
      // junk above the count field must be ignored
      cnt = ($urandom & 32'hFFFF_FFE0) | cnt;

      settle_idle();
      calm <= (p == 5);  // the long no-idle stretch
      write_config(fa, sa, cnt);

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // sender holds off mid-phase until the block has delivered everything
        if (p == 2 && n == ITEMS_PER_PHASE / 2) settle_idle();
        if ($urandom_range(99) < 20) it = make_load(SLOT_W'($urandom_range(0, SLOTS - 1)));
        else it = make_xlate();
        drive_item(it);
      end
    end

    settle_idle();
    calm <= 1'b0;

    $display("Covered %0d section loads and %0d translations (%0d hits, %0d not found)",
             ledger.loads, ledger.hits + ledger.misses, ledger.hits, ledger.misses);
    $display("across %0d register settings incl. zero/odd/huge alignments and count > 16",
             RANDOM_PHASES + 2);
    if (ledger.mismatches == 0 && ledger.pending_offsets.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results never arrived", ledger.mismatches,
               ledger.pending_offsets.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/srfo_pkg.sv
hdl/srfo_ram.sv
hdl/section_rva_to_file_offset_top.sv
sim/testbench.sv
